// ----- hw/rtl/tcl_pkg.sv -----
// ----------------------------------------------------------------------------
// tcl_pkg
// Shared types and constants of the tile cache refresh block: payload words,
// configuration registers and the slot store request/response bundles.
// ----------------------------------------------------------------------------
`default_nettype none

package tcl_pkg;

  localparam int CACHE_SLOTS_DEF = 16;
  localparam int MAX_LOADS_DEF   = 3;
  localparam int MAX_SLOTS       = 64;
  localparam int SLOT_IDX_W      = 6;

  // tile edge in map pixels, a power of two
  localparam int TILE_PIXELS = 256;
  localparam int TILE_SHIFT  = $clog2(TILE_PIXELS);

  localparam int COORD_W = 8;
  localparam int STAMP_W = 32;
  localparam int CFG_W   = 11;

  // configuration register indexes
  localparam logic [1:0] CFG_GRID_COLUMNS    = 2'd0;
  localparam logic [1:0] CFG_GRID_ROWS       = 2'd1;
  localparam logic [1:0] CFG_VIEWPORT_WIDTH  = 2'd2;
  localparam logic [1:0] CFG_VIEWPORT_HEIGHT = 2'd3;

  typedef struct packed {
    logic [15:0] view_left;
    logic [15:0] view_top;
  } in_word_t;

  typedef struct packed {
    logic         is_load;
    logic [3:0]   target_slot;
    logic [7:0]   tile_column;
    logic [7:0]   tile_row;
    logic         more_pending;
    logic         last_of_run;
  } out_word_t;

  typedef struct packed {
    logic [8:0]  grid_columns;
    logic [8:0]  grid_rows;
    logic [10:0] viewport_width;
    logic [10:0] viewport_height;
  } cfg_t;

  typedef struct packed {
    logic [SLOT_IDX_W-1:0] rd_addr;
    logic [SLOT_IDX_W-1:0] wr_addr;
    logic                  stamp_we;   // writes the age stamp, marks the slot needed
    logic                  tag_we;     // writes the tag, marks the slot valid
    logic [COORD_W-1:0]    wr_col;
    logic [COORD_W-1:0]    wr_row;
    logic [STAMP_W-1:0]    wr_stamp;
    logic                  clr_needed;
  } store_req_t;

  typedef struct packed {
    logic [COORD_W-1:0] tag_col;
    logic [COORD_W-1:0] tag_row;
    logic [STAMP_W-1:0] stamp;
    logic               valid;
    logic               needed;
  } store_rsp_t;

endpackage

`default_nettype wire

// ----- hw/rtl/tcl_slot_store.sv -----
// ----------------------------------------------------------------------------
// tcl_slot_store
// Tag and age stamp memories of the cache slots, with per-slot valid and
// needed flags. One registered read port, one write port.
// ----------------------------------------------------------------------------
`default_nettype none

module tcl_slot_store #(
  parameter int CACHE_SLOTS = tcl_pkg::CACHE_SLOTS_DEF
) (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire tcl_pkg::store_req_t req,
  output tcl_pkg::store_rsp_t      rsp
);

  localparam int IDX_W = (CACHE_SLOTS > 1) ? $clog2(CACHE_SLOTS) : 1;

  logic [2*tcl_pkg::COORD_W-1:0] tag_mem   [CACHE_SLOTS];
  logic [tcl_pkg::STAMP_W-1:0]   stamp_mem [CACHE_SLOTS];
  logic [CACHE_SLOTS-1:0]        valid;
  logic [CACHE_SLOTS-1:0]        needed;

  logic [2*tcl_pkg::COORD_W-1:0] tag_q;
  logic [tcl_pkg::STAMP_W-1:0]   stamp_q;
  logic                          valid_q;
  logic                          needed_q;

  logic [IDX_W-1:0] ra;
  logic [IDX_W-1:0] wa;

  assign ra = req.rd_addr[IDX_W-1:0];
  assign wa = req.wr_addr[IDX_W-1:0];

  always_ff @(posedge clk) begin
    if (req.tag_we) begin
      tag_mem[wa] <= {req.wr_col, req.wr_row};
    end
    if (req.stamp_we) begin
      stamp_mem[wa] <= req.wr_stamp;
    end
    tag_q   <= tag_mem[ra];
    stamp_q <= stamp_mem[ra];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid    <= '0;
      needed   <= '0;
      valid_q  <= 1'b0;
      needed_q <= 1'b0;
    end else begin
      if (req.tag_we) begin
        valid[wa] <= 1'b1;
      end
      if (req.clr_needed) begin
        needed <= '0;
      end else if (req.stamp_we) begin
        needed[wa] <= 1'b1;
      end
      valid_q  <= valid[ra];
      needed_q <= needed[ra];
    end
  end

  // a slot never loaded reads with a zero stamp
  assign rsp.tag_col = tag_q[2*tcl_pkg::COORD_W-1:tcl_pkg::COORD_W];
  assign rsp.tag_row = tag_q[tcl_pkg::COORD_W-1:0];
  assign rsp.stamp   = valid_q ? stamp_q : '0;
  assign rsp.valid   = valid_q;
  assign rsp.needed  = needed_q;

endmodule

`default_nettype wire

// ----- hw/rtl/tcl_seq.sv -----
// ----------------------------------------------------------------------------
// tcl_seq
// Refresh sequencer: forms the visible tile rectangle, scans the slot store
// once per tile for a hit, then scans it once per queued miss for the oldest
// slot not needed, and emits load words and the closing status word.
// ----------------------------------------------------------------------------
`default_nettype none

module tcl_seq #(
  parameter int CACHE_SLOTS = tcl_pkg::CACHE_SLOTS_DEF,
  parameter int MAX_LOADS   = tcl_pkg::MAX_LOADS_DEF
) (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire tcl_pkg::cfg_t       cfg,
  input  wire logic                in_valid,
  output logic                     in_stall,
  input  wire tcl_pkg::in_word_t   in_word,
  input  wire logic                out_free,
  output logic                     res_valid,
  output tcl_pkg::out_word_t       res_word,
  output tcl_pkg::store_req_t      req,
  input  wire tcl_pkg::store_rsp_t rsp
);

  localparam int IDX_W = (CACHE_SLOTS > 1) ? $clog2(CACHE_SLOTS) : 1;
  localparam int CNT_W = $clog2(CACHE_SLOTS + 1);
  localparam int MC_W  = $clog2(MAX_LOADS + 1);
  localparam int MI_W  = (MAX_LOADS > 1) ? $clog2(MAX_LOADS) : 1;
  localparam int EXT_W = 17;

  typedef enum logic [5:0] {
    ST_IDLE   = 6'b000001,
    ST_SETUP  = 6'b000010,
    ST_LOOK   = 6'b000100,
    ST_EVICT  = 6'b001000,
    ST_EMIT   = 6'b010000,
    ST_STATUS = 6'b100000
  } state_t;

  state_t state;

  logic [15:0]                 vx;
  logic [15:0]                 vy;
  logic [tcl_pkg::STAMP_W-1:0] frame_count;

  logic [tcl_pkg::COORD_W-1:0] c0, c1, r1, cur_c, cur_r;
  logic [CNT_W-1:0]            vis_cnt;

  // scan pipeline over the slots
  logic [CNT_W-1:0] addr_cnt;
  logic             chk_vld;
  logic [IDX_W-1:0] chk_idx;
  logic             chk_last;

  logic [tcl_pkg::COORD_W-1:0] miss_col [MAX_LOADS];
  logic [tcl_pkg::COORD_W-1:0] miss_row [MAX_LOADS];
  logic [MC_W-1:0]             miss_cnt;
  logic [MI_W-1:0]             ld_idx;
  logic                        more;

  logic [IDX_W-1:0]            best_idx;
  logic [tcl_pkg::STAMP_W-1:0] best_stamp;
  logic                        best_found;

  // rectangle setup
  logic [8:0]       gc, gr;
  logic [10:0]      vw, vh;
  logic [EXT_W-1:0] x_end, y_end, c0w, r0w, c1w, r1w, c1c, r1c;
  logic             rect_empty;

  logic hit, better, tile_done, last_tile, have_miss, last_load, scan_restart;

  always_comb begin
    gc    = (cfg.grid_columns > 9'd256) ? 9'd256 : cfg.grid_columns;
    gr    = (cfg.grid_rows > 9'd256) ? 9'd256 : cfg.grid_rows;
    vw    = (cfg.viewport_width == '0) ? 11'd1 : cfg.viewport_width;
    vh    = (cfg.viewport_height == '0) ? 11'd1 : cfg.viewport_height;
    x_end = EXT_W'(vx) + EXT_W'(vw) - EXT_W'(1);
    y_end = EXT_W'(vy) + EXT_W'(vh) - EXT_W'(1);
    c0w   = EXT_W'(vx) >> tcl_pkg::TILE_SHIFT;
    r0w   = EXT_W'(vy) >> tcl_pkg::TILE_SHIFT;
    c1w   = x_end >> tcl_pkg::TILE_SHIFT;
    r1w   = y_end >> tcl_pkg::TILE_SHIFT;
    c1c   = (c1w > EXT_W'(gc) - EXT_W'(1)) ? EXT_W'(gc) - EXT_W'(1) : c1w;
    r1c   = (r1w > EXT_W'(gr) - EXT_W'(1)) ? EXT_W'(gr) - EXT_W'(1) : r1w;
    rect_empty = (gc == '0) || (gr == '0) || (c0w > c1c) || (r0w > r1c);
  end

  assign chk_last = (chk_idx == IDX_W'(CACHE_SLOTS - 1));

  // the slot compares: tag match while looking up, age order while evicting
  assign hit = chk_vld && rsp.valid && (rsp.tag_col == cur_c) && (rsp.tag_row == cur_r);
  assign better = chk_vld && !rsp.needed && (!best_found || (rsp.stamp < best_stamp));

  assign tile_done = hit || (chk_vld && chk_last);
  assign last_tile = (vis_cnt == CNT_W'(CACHE_SLOTS - 1)) || ((cur_c == c1) && (cur_r == r1));
  assign have_miss = (miss_cnt != '0) || !hit;
  assign last_load = ((MC_W'(ld_idx) + MC_W'(1)) == miss_cnt);

  assign scan_restart = ((state == ST_LOOK) && tile_done) ||
                        ((state == ST_EVICT) && chk_vld && chk_last);

  assign in_stall = (state != ST_IDLE);

  always_comb begin
    req            = '0;
    req.rd_addr    = tcl_pkg::SLOT_IDX_W'(addr_cnt[IDX_W-1:0]);
    req.wr_stamp   = frame_count;
    req.wr_col     = miss_col[ld_idx];
    req.wr_row     = miss_row[ld_idx];
    req.clr_needed = (state == ST_IDLE) && in_valid;
    res_valid      = 1'b0;
    res_word       = '0;
    unique case (state)
      ST_LOOK: begin
        req.wr_addr  = tcl_pkg::SLOT_IDX_W'(chk_idx);
        req.stamp_we = hit;
      end
      ST_EMIT: begin
        req.wr_addr          = tcl_pkg::SLOT_IDX_W'(best_idx);
        req.stamp_we         = out_free;
        req.tag_we           = out_free;
        res_valid            = out_free;
        res_word.is_load     = 1'b1;
        res_word.target_slot = 4'(best_idx);
        res_word.tile_column = miss_col[ld_idx];
        res_word.tile_row    = miss_row[ld_idx];
      end
      ST_STATUS: begin
        res_valid             = out_free;
        res_word.more_pending = more;
        res_word.last_of_run  = 1'b1;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= ST_IDLE;
      frame_count <= '0;
      addr_cnt    <= '0;
      chk_vld     <= 1'b0;
      miss_cnt    <= '0;
      ld_idx      <= '0;
      more        <= 1'b0;
      best_found  <= 1'b0;
      vis_cnt     <= '0;
    end else begin
      // slot scan advances in the two scanning states, restarts after each scan
      if (scan_restart) begin
        addr_cnt <= '0;
        chk_vld  <= 1'b0;
      end else if ((state == ST_LOOK) || (state == ST_EVICT)) begin
        if (addr_cnt < CNT_W'(CACHE_SLOTS)) begin
          addr_cnt <= addr_cnt + CNT_W'(1);
          chk_vld  <= 1'b1;
          chk_idx  <= addr_cnt[IDX_W-1:0];
        end else begin
          chk_vld <= 1'b0;
        end
      end

      unique case (state)
        ST_IDLE: begin
          if (in_valid) begin
            vx          <= in_word.view_left;
            vy          <= in_word.view_top;
            frame_count <= frame_count + 32'd1;
            miss_cnt    <= '0;
            more        <= 1'b0;
            vis_cnt     <= '0;
            state       <= ST_SETUP;
          end
        end
        ST_SETUP: begin
          c0       <= c0w[7:0];
          c1       <= c1c[7:0];
          r1       <= r1c[7:0];
          cur_c    <= c0w[7:0];
          cur_r    <= r0w[7:0];
          addr_cnt <= '0;
          chk_vld  <= 1'b0;
          state    <= rect_empty ? ST_STATUS : ST_LOOK;
        end
        ST_LOOK: begin
          if (tile_done) begin
            if (!hit) begin
              if (miss_cnt < MC_W'(MAX_LOADS)) begin
                miss_col[miss_cnt[MI_W-1:0]] <= cur_c;
                miss_row[miss_cnt[MI_W-1:0]] <= cur_r;
                miss_cnt <= miss_cnt + MC_W'(1);
              end else begin
                more <= 1'b1;
              end
            end
            if (last_tile) begin
              ld_idx     <= '0;
              best_found <= 1'b0;
              state      <= have_miss ? ST_EVICT : ST_STATUS;
            end else begin
              vis_cnt <= vis_cnt + CNT_W'(1);
              if (cur_c == c1) begin
                cur_c <= c0;
                cur_r <= cur_r + 8'd1;
              end else begin
                cur_c <= cur_c + 8'd1;
              end
            end
          end
        end
        ST_EVICT: begin
          if (better) begin
            best_idx   <= chk_idx;
            best_stamp <= rsp.stamp;
            best_found <= 1'b1;
          end
          if (chk_vld && chk_last) begin
            state <= (best_found || better) ? ST_EMIT : ST_STATUS;
          end
        end
        ST_EMIT: begin
          if (out_free) begin
            best_found <= 1'b0;
            if (last_load) begin
              state <= ST_STATUS;
            end else begin
              ld_idx <= ld_idx + MI_W'(1);
              state  <= ST_EVICT;
            end
          end
        end
        ST_STATUS: begin
          if (out_free) begin
            state <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

`ifndef NO_ASSERTIONS
  a_res_into_free: assert property (@(posedge clk) disable iff (rst)
    res_valid |-> out_free)
    else $error("result word issued while the output register is occupied");

  a_miss_bound: assert property (@(posedge clk) disable iff (rst)
    miss_cnt <= MC_W'(MAX_LOADS))
    else $error("miss queue overflow");

  a_tag_write_emit: assert property (@(posedge clk) disable iff (rst)
    req.tag_we |-> (state == ST_EMIT) && res_valid && res_word.is_load)
    else $error("slot retagged without a load word");

  a_status_ends_run: assert property (@(posedge clk) disable iff (rst)
    (res_valid && res_word.last_of_run) |=> (state == ST_IDLE))
    else $error("sequencer not idle after the status word");
`endif

endmodule

`default_nettype wire

// ----- hw/rtl/tile_cache_lru_refresh_top.sv -----
// ----------------------------------------------------------------------------
// tile_cache_lru_refresh_top
// Fully associative LRU tile cache refresh: per viewport request, looks up
// the visible tiles and issues slot load commands plus a status word.
// ----------------------------------------------------------------------------
// One request passes through setup, a lookup scan per visited tile (cut
// short on a hit: the scan stops at the matching slot), an eviction search
// per load and the status word. Its pace is set by the single read port of
// the slot store, which is stepped one slot a cycle for every lookup and
// every eviction search. A new request is taken only after the previous one
// has issued its status word; results leave through an output register, and
// an occupied register that is stalled holds the sequencer. No clearing pass
// is needed after reset.
`default_nettype none

module tile_cache_lru_refresh_top #(
  parameter int CACHE_SLOTS = tcl_pkg::CACHE_SLOTS_DEF,
  parameter int MAX_LOADS   = tcl_pkg::MAX_LOADS_DEF
) (
  input  wire logic                     clk,
  input  wire logic                     rst,
  input  wire logic                     cfg_write,
  input  wire logic [1:0]               cfg_index,
  input  wire logic [tcl_pkg::CFG_W-1:0] cfg_data,
  input  wire logic                     in_valid,
  output logic                          in_stall,
  input  wire tcl_pkg::in_word_t        in_word,
  output logic                          out_valid,
  input  wire logic                     out_stall,
  output tcl_pkg::out_word_t            out_word
);

  tcl_pkg::cfg_t       cfg;
  tcl_pkg::store_req_t req;
  tcl_pkg::store_rsp_t rsp;
  tcl_pkg::out_word_t  res_word;
  logic                res_valid;
  logic                out_free;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.grid_columns    <= 9'd1;
      cfg.grid_rows       <= 9'd1;
      cfg.viewport_width  <= 11'd800;
      cfg.viewport_height <= 11'd480;
    end else if (cfg_write) begin
      unique case (cfg_index)
        tcl_pkg::CFG_GRID_COLUMNS:    cfg.grid_columns    <= cfg_data[8:0];
        tcl_pkg::CFG_GRID_ROWS:       cfg.grid_rows       <= cfg_data[8:0];
        tcl_pkg::CFG_VIEWPORT_WIDTH:  cfg.viewport_width  <= cfg_data;
        tcl_pkg::CFG_VIEWPORT_HEIGHT: cfg.viewport_height <= cfg_data;
      endcase
    end
  end

  tcl_slot_store #(
    .CACHE_SLOTS (CACHE_SLOTS)
  ) u_store (
    .clk (clk),
    .rst (rst),
    .req (req),
    .rsp (rsp)
  );

  tcl_seq #(
    .CACHE_SLOTS (CACHE_SLOTS),
    .MAX_LOADS   (MAX_LOADS)
  ) u_seq (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_word   (in_word),
    .out_free  (out_free),
    .res_valid (res_valid),
    .res_word  (res_word),
    .req       (req),
    .rsp       (rsp)
  );

  // output register: takes a new word when empty or being drained
  assign out_free = !out_valid || !out_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (res_valid) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid) begin
      out_word <= res_word;
    end
  end

endmodule

`default_nettype wire
